// ----- sv/dfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dfd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_MODE     = 2'd2;

  localparam logic [15:0] LEN_RESET = 16'd32768;
  localparam logic [15:0] DLY_RESET = 16'd32767;

  localparam int MOD_BITS      = 24;
  localparam int MOD_FRAC_BITS = 8;
  localparam int GLIDE_COEF    = 429497;
  localparam int GLIDE_SHIFT   = 32;
  localparam int COEF_BITS     = 20;

  typedef enum logic [1:0] {
    MODE_GLIDE     = 2'd0,
    MODE_GLIDE_MOD = 2'd1,
    MODE_TAP       = 2'd2,
    MODE_CHORUS    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [15:0] buffer_length;
    logic [15:0] delay_samples;
    mode_e       read_mode;
  } cfg_t;

  typedef enum logic {
    DIV_MOD,
    DIV_QUO
  } div_op_e;

  typedef struct packed {
    logic    start;
    div_op_e op;
  } div_ctl_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_WP, ST_WP_W, ST_HD, ST_HD_W, ST_WRITE, ST_MOD, ST_MOD_W,
    ST_RD_A, ST_RD_B, ST_MUL, ST_SUM, ST_GDIV, ST_GDIV_W, ST_GMUL, ST_GSH, ST_GADD,
    ST_CH, ST_HEAD_W, ST_TAP_RD, ST_TAP_W, ST_DONE
  } back_state_e;

endpackage
`default_nettype wire

// ----- sv/dfd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface dfd_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                                 valid;
  logic                                 ready;
  logic signed [SAMPLE_BITS-1:0]        sample_in;
  logic signed [dfd_pkg::MOD_BITS-1:0]  modulation;
  logic                                 snap;

  modport source (output valid, output sample_in, output modulation, output snap, input ready);
  modport sink (input valid, input sample_in, input modulation, input snap, output ready);
endinterface

interface dfd_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ----- sv/dfd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- sv/dfd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// one bit per cycle restoring divider: floored modulo or truncated quotient
module dfd_div #(
  parameter int XW = 37,
  parameter int DW = 36
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dfd_pkg::div_ctl_t    ctl_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic [DW-1:0]        m_i,
  output      logic                 done_o,
  output      logic signed [XW-1:0] res_o
);
  localparam int CW   = $clog2(XW + 1);
  localparam int CMPW = (XW > DW) ? XW : DW;

  logic                 busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]        cnt_q;
  dfd_pkg::div_op_e     op_q;
  logic                 neg_q;
  logic [DW-1:0]        m_q, rem_q, rm;
  logic [XW-1:0]        num_q, ax;
  logic signed [XW-1:0] res_q, fin;
  logic [DW:0]          trial, sub;
  logic                 take, fast;

  assign ax    = x_i[XW-1] ? $unsigned(-x_i) : $unsigned(x_i);
  assign fast  = (ctl_i.op == dfd_pkg::DIV_MOD) && !x_i[XW-1] &&
                 (CMPW'($unsigned(x_i)) < CMPW'(m_i));
  assign trial = {rem_q, num_q[XW-1]};
  assign sub   = trial - {1'b0, m_q};
  assign take  = !sub[DW];
  assign rm    = (neg_q && (rem_q != '0)) ? (m_q - rem_q) : rem_q;

  always_comb begin
    if (op_q == dfd_pkg::DIV_MOD) begin
      fin = $signed(XW'(rm));
    end else begin
      fin = neg_q ? -$signed(num_q) : $signed(num_q);
    end
  end

  always_comb begin
    if (ctl_i.start) begin
      busy_d = !fast;
      done_d = fast;
    end else begin
      busy_d = busy_q && (cnt_q != '0);
      done_d = busy_q && (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q  <= ctl_i.op;
      neg_q <= x_i[XW-1];
      m_q   <= m_i;
      num_q <= ax;
      rem_q <= '0;
      cnt_q <= CW'(XW);
      res_q <= x_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        num_q <= {num_q[XW-2:0], take};
        rem_q <= take ? sub[DW-1:0] : trial[DW-1:0];
        cnt_q <= cnt_q - 1'b1;
      end else begin
        res_q <= fin;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire

// ----- sv/dfd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// two entry input queue
module dfd_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  dfd_in_if.sink                                   in_i,
  output      logic                                valid_o,
  input  wire logic                                pop_i,
  output      logic signed [SAMPLE_BITS-1:0]       sample_o,
  output      logic signed [dfd_pkg::MOD_BITS-1:0] mod_o,
  output      logic                                snap_o
);
  localparam int IW = SAMPLE_BITS + dfd_pkg::MOD_BITS + 1;

  logic [IW-1:0] ent_q [2];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  logic [IW-1:0] head;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != 2'd0);
  assign valid_o    = (cnt_q != 2'd0);
  assign head       = ent_q[rd_q];
  assign sample_o   = $signed(head[IW-1 -: SAMPLE_BITS]);
  assign mod_o      = $signed(head[dfd_pkg::MOD_BITS:1]);
  assign snap_o     = head[0];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= {in_i.sample_in, in_i.modulation, in_i.snap};
    end
  end
endmodule
`default_nettype wire

// ----- sv/dfd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sequencer that writes, reads, interpolates and moves the read head
module dfd_back #(
  parameter int DEPTH          = 32768,
  parameter int SAMPLE_BITS    = 24,
  parameter int HEAD_FRAC_BITS = 20
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dfd_pkg::cfg_t                       cfg_i,
  input  wire logic                                item_valid_i,
  output      logic                                item_pop_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       item_sample_i,
  input  wire logic signed [dfd_pkg::MOD_BITS-1:0] item_mod_i,
  input  wire logic                                item_snap_i,
  dfd_out_if.source                                out_o
);
  localparam int F  = HEAD_FRAC_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int LW = AW + 1;
  localparam int HW = AW + F;
  localparam int XW = ((HW > F + 15) ? HW : F + 15) + 2;
  localparam int DW = HW + 1;
  localparam int CW = (LW > 16) ? LW : 16;
  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + F + 2;
  localparam int GW = XW + dfd_pkg::COEF_BITS;
  localparam logic [HW-1:0] HEAD_ONE = {{(AW-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [dfd_pkg::COEF_BITS-1:0] GCOEF =
    dfd_pkg::COEF_BITS'(dfd_pkg::GLIDE_COEF);

  // (w + l - (k - 1)) mod l, for w < l and 1 <= k <= l
  function automatic logic [AW-1:0] back_off(input logic [AW-1:0] w, input logic [LW-1:0] l,
                                             input logic [LW-1:0] k);
    logic [LW:0] s;
    s = (LW+1)'(w) + (LW+1)'(l) - (LW+1)'(k) + (LW+1)'(1);
    if (s >= (LW+1)'(l)) s = s - (LW+1)'(l);
    return s[AW-1:0];
  endfunction

  dfd_pkg::back_state_e state_q, state_d;

  // saturated configuration
  logic [CW-1:0] len_raw, dly_raw, len_c, dly_c;
  logic [LW-1:0] len, dly, lm1;
  logic [DW-1:0] lenf;

  assign len_raw = CW'(cfg_i.buffer_length);
  assign dly_raw = CW'(cfg_i.delay_samples);
  assign len_c   = (len_raw < CW'(2)) ? CW'(2) : ((len_raw > CW'(DEPTH)) ? CW'(DEPTH) : len_raw);
  assign dly_c   = (dly_raw < CW'(1)) ? CW'(1) : ((dly_raw > len_c) ? len_c : dly_raw);
  assign len     = len_c[LW-1:0];
  assign dly     = dly_c[LW-1:0];
  assign lm1     = len - LW'(1);
  assign lenf    = {len, {F{1'b0}}};

  // state and working registers
  logic [AW-1:0]        clr_q, wpt_q, wp_q, wp1_q;
  logic [HW-1:0]        pos_q, head_q, p_q;
  logic signed [SB-1:0] smp_q, a_q, outv_q, out_data_q;
  logic signed [dfd_pkg::MOD_BITS-1:0] modv_q;
  logic                 snap_q, out_valid_q;
  logic signed [PW-1:0] prod_q, prod_c, shp;
  logic signed [XW-1:0] d_q, g_q, d_c;
  logic signed [GW-1:0] gprod_q, gsh;

  // memory and divider
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [SB-1:0]        ram_wdata, ram_rdata;
  dfd_pkg::div_ctl_t    div_ctl;
  logic signed [XW-1:0] div_x, div_res;
  logic [DW-1:0]        div_m;
  logic                 div_done;

  dfd_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dfd_div #(.XW(XW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .x_i    (div_x),
    .m_i    (div_m),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // datapath helpers
  logic [AW-1:0]        wp1_c, ip, im;
  logic [F-1:0]         fr;
  logic signed [SB:0]   diff;
  logic signed [F:0]    fs;
  logic signed [XW-1:0] mod_ext, mod1_x, cx_n, ch_x, gadd_x, rmw, wmt, d0, lenfx;
  logic [LW:0]          tg_s;
  logic [AW-1:0]        tgt;
  logic [HW-1:0]        tgtf, wpf;
  logic                 out_free;

  assign wp1_c   = ((LW'(wp_q) + LW'(1)) == len) ? '0 : (wp_q + 1'b1);
  assign ip      = p_q[HW-1:F];
  assign im      = (ip == '0) ? lm1[AW-1:0] : (ip - 1'b1);
  assign fr      = p_q[F-1:0];
  assign diff    = $signed({ram_rdata[SB-1], ram_rdata}) - $signed({a_q[SB-1], a_q});
  assign fs      = $signed({1'b0, fr});
  assign prod_c  = diff * fs;
  assign shp     = prod_q >>> F;
  assign mod_ext = XW'(modv_q) <<< (F - dfd_pkg::MOD_FRAC_BITS);
  assign mod1_x  = $signed(XW'(head_q)) + mod_ext;
  assign cx_n    = $signed(XW'(wp1_q)) - $signed(XW'(dly)) + $signed(XW'(1));
  assign ch_x    = (cx_n <<< F) + mod_ext;
  assign gadd_x  = $signed(XW'(head_q)) + $signed(XW'(HEAD_ONE)) + g_q;
  assign gsh     = gprod_q >>> dfd_pkg::GLIDE_SHIFT;
  assign out_free = !out_valid_q || out_o.ready;

  // wrapped distance from head to target
  assign tg_s  = (LW+1)'(wp1_q) - (LW+1)'(dly);
  assign tgt   = tg_s[LW] ? (tg_s[AW-1:0] + len[AW-1:0]) : tg_s[AW-1:0];
  assign tgtf  = {tgt, {F{1'b0}}};
  assign wpf   = {wp1_q, {F{1'b0}}};
  assign lenfx = $signed(XW'(lenf));
  assign d0    = $signed(XW'(tgtf)) - $signed(XW'(head_q));
  assign rmw   = $signed(XW'(head_q)) - $signed(XW'(wpf));
  assign wmt   = $signed(XW'(wpf)) - $signed(XW'(tgtf));
  always_comb begin
    if (rmw < 0 && wmt < 0) begin
      d_c = d0 - lenfx;
    end else if (rmw > 0 && wmt > 0) begin
      d_c = d0 + lenfx;
    end else begin
      d_c = d0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dfd_pkg::ST_CLEAR:  if (clr_q == AW'(DEPTH - 1)) state_d = dfd_pkg::ST_IDLE;
      dfd_pkg::ST_IDLE:   if (item_valid_i) state_d = dfd_pkg::ST_WP;
      dfd_pkg::ST_WP:     state_d = dfd_pkg::ST_WP_W;
      dfd_pkg::ST_WP_W:   if (div_done) state_d = dfd_pkg::ST_HD;
      dfd_pkg::ST_HD:     state_d = dfd_pkg::ST_HD_W;
      dfd_pkg::ST_HD_W:   if (div_done) state_d = dfd_pkg::ST_WRITE;
      dfd_pkg::ST_WRITE: begin
        unique case (cfg_i.read_mode)
          dfd_pkg::MODE_TAP:       state_d = dfd_pkg::ST_TAP_RD;
          dfd_pkg::MODE_GLIDE_MOD: state_d = dfd_pkg::ST_MOD;
          default:                 state_d = dfd_pkg::ST_RD_A;
        endcase
      end
      dfd_pkg::ST_MOD:    state_d = dfd_pkg::ST_MOD_W;
      dfd_pkg::ST_MOD_W:  if (div_done) state_d = dfd_pkg::ST_RD_A;
      dfd_pkg::ST_RD_A:   state_d = dfd_pkg::ST_RD_B;
      dfd_pkg::ST_RD_B:   state_d = dfd_pkg::ST_MUL;
      dfd_pkg::ST_MUL:    state_d = dfd_pkg::ST_SUM;
      dfd_pkg::ST_SUM: begin
        unique case (cfg_i.read_mode)
          dfd_pkg::MODE_CHORUS:    state_d = dfd_pkg::ST_CH;
          dfd_pkg::MODE_GLIDE_MOD: state_d = dfd_pkg::ST_GMUL;
          default:                 state_d = dfd_pkg::ST_GDIV;
        endcase
      end
      dfd_pkg::ST_GDIV:   state_d = dfd_pkg::ST_GDIV_W;
      dfd_pkg::ST_GDIV_W: if (div_done) state_d = dfd_pkg::ST_GADD;
      dfd_pkg::ST_GMUL:   state_d = dfd_pkg::ST_GSH;
      dfd_pkg::ST_GSH:    state_d = dfd_pkg::ST_GADD;
      dfd_pkg::ST_GADD:   state_d = dfd_pkg::ST_HEAD_W;
      dfd_pkg::ST_CH:     state_d = dfd_pkg::ST_HEAD_W;
      dfd_pkg::ST_HEAD_W: if (div_done) state_d = dfd_pkg::ST_DONE;
      dfd_pkg::ST_TAP_RD: state_d = dfd_pkg::ST_TAP_W;
      dfd_pkg::ST_TAP_W:  state_d = dfd_pkg::ST_DONE;
      dfd_pkg::ST_DONE:   if (out_free) state_d = dfd_pkg::ST_IDLE;
      default:            state_d = dfd_pkg::ST_IDLE;
    endcase
  end

  // outputs to memory, divider and queue
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = wp_q;
    ram_wdata     = smp_q;
    ram_raddr     = im;
    div_ctl.start = 1'b0;
    div_ctl.op    = dfd_pkg::DIV_MOD;
    div_x         = gadd_x;
    div_m         = lenf;
    item_pop_o    = 1'b0;
    unique case (state_q)
      dfd_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      dfd_pkg::ST_IDLE:   item_pop_o = item_valid_i;
      dfd_pkg::ST_WP: begin
        div_ctl.start = 1'b1;
        div_x         = $signed(XW'(wpt_q));
        div_m         = DW'(len);
      end
      dfd_pkg::ST_HD: begin
        div_ctl.start = 1'b1;
        div_x         = $signed(XW'(pos_q));
      end
      dfd_pkg::ST_WRITE:  ram_we = 1'b1;
      dfd_pkg::ST_MOD: begin
        div_ctl.start = 1'b1;
        div_x         = mod1_x;
      end
      dfd_pkg::ST_RD_B:   ram_raddr = ip;
      dfd_pkg::ST_GDIV: begin
        div_ctl.start = 1'b1;
        div_ctl.op    = dfd_pkg::DIV_QUO;
        div_x         = d_q;
        div_m         = DW'(len);
      end
      dfd_pkg::ST_GADD:   div_ctl.start = 1'b1;
      dfd_pkg::ST_CH: begin
        div_ctl.start = 1'b1;
        div_x         = ch_x;
      end
      dfd_pkg::ST_TAP_RD: ram_raddr = back_off(wp1_q, len, dly);
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfd_pkg::ST_CLEAR;
      clr_q       <= '0;
      wpt_q       <= '0;
      pos_q       <= HEAD_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dfd_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == dfd_pkg::ST_DONE && out_free) begin
        wpt_q       <= wp1_q;
        pos_q       <= head_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      dfd_pkg::ST_IDLE: begin
        smp_q  <= item_sample_i;
        modv_q <= item_mod_i;
        snap_q <= item_snap_i;
      end
      dfd_pkg::ST_WP_W: if (div_done) wp_q <= div_res[AW-1:0];
      dfd_pkg::ST_HD_W: begin
        if (div_done) begin
          head_q <= snap_q ? {back_off(wp_q, len, dly), {F{1'b0}}} : div_res[HW-1:0];
        end
      end
      dfd_pkg::ST_WRITE: begin
        wp1_q <= wp1_c;
        p_q   <= head_q;
      end
      dfd_pkg::ST_MOD_W:  if (div_done) p_q <= div_res[HW-1:0];
      dfd_pkg::ST_RD_B:   a_q <= ram_rdata;
      dfd_pkg::ST_MUL:    prod_q <= prod_c;
      dfd_pkg::ST_SUM: begin
        outv_q <= a_q + shp[SB-1:0];
        d_q    <= d_c;
      end
      dfd_pkg::ST_GDIV_W: if (div_done) g_q <= div_res;
      dfd_pkg::ST_GMUL:   gprod_q <= d_q * GCOEF;
      dfd_pkg::ST_GSH:    g_q <= gsh[XW-1:0];
      dfd_pkg::ST_HEAD_W: if (div_done) head_q <= div_res[HW-1:0];
      dfd_pkg::ST_TAP_W:  outv_q <= ram_rdata;
      dfd_pkg::ST_DONE:   if (out_free) out_data_q <= outv_q;
      default: begin
      end
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;
endmodule
`default_nettype wire

// ----- sv/gliding_fractional_delay_line.sv -----
`timescale 1ns / 1ps
`default_nettype none
// path length: the integer tap mode (positions already in range) is the shortest path and the
//   modulated glide mode (every division full length) the longest; XW = max(AW+F, F+15)+2, which
//   is 37 at the defaults, and a remainder of an in-range value skips the bit-serial division
// transactions: sequential, the next transaction starts once the result is registered
// reset: asynchronous, active low; a clearing pass then zeroes every word of the store,
//   during which transactions queue in the front end but none is processed
module gliding_fractional_delay_line #(
  parameter int DEPTH          = 32768,
  parameter int SAMPLE_BITS    = 24,
  parameter int HEAD_FRAC_BITS = 20
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  dfd_in_if.sink                                  in_i,
  dfd_out_if.source                               out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [dfd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [dfd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  // configuration registers; the user must write them only while idle, the block does not enforce it
  dfd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_length <= dfd_pkg::LEN_RESET;
      cfg_q.delay_samples <= dfd_pkg::DLY_RESET;
      cfg_q.read_mode     <= dfd_pkg::MODE_GLIDE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfd_pkg::REG_BUFFER_LENGTH: cfg_q.buffer_length <= cfg_data_i;
        dfd_pkg::REG_DELAY_SAMPLES: cfg_q.delay_samples <= cfg_data_i;
        dfd_pkg::REG_READ_MODE:     cfg_q.read_mode     <= dfd_pkg::mode_e'(cfg_data_i[1:0]);
        default: begin
          // unmapped index, write is dropped
        end
      endcase
    end
  end

  // front end: queue between the input channel and the sequencer
  logic                                item_valid, item_pop, item_snap;
  logic signed [SAMPLE_BITS-1:0]       item_sample;
  logic signed [dfd_pkg::MOD_BITS-1:0] item_mod;

  dfd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .valid_o  (item_valid),
    .pop_i    (item_pop),
    .sample_o (item_sample),
    .mod_o    (item_mod),
    .snap_o   (item_snap)
  );

  // back end: store write, interpolated read, head glide, output register
  dfd_back #(
    .DEPTH          (DEPTH),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .HEAD_FRAC_BITS (HEAD_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .item_sample_i (item_sample),
    .item_mod_i    (item_mod),
    .item_snap_i   (item_snap),
    .out_o         (out_o)
  );
endmodule
`default_nettype wire
